FILE: hw/rtl/tga_pkg.sv
// Shared types and constants for the truecolor TGA run-length decoder.
package tga_pkg;

    // Decoder phase while walking through one file.
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_IDSKIP = 3'd1,
        PH_PACKET = 3'd2,
        PH_PIXEL  = 3'd3,
        PH_IDLE   = 3'd4
    } t_phase;

    // Result kinds.
    localparam logic [1:0] KIND_HDR_OK  = 2'd0;
    localparam logic [1:0] KIND_HDR_BAD = 2'd1;
    localparam logic [1:0] KIND_SPAN    = 2'd2;

    // Header byte positions (little-endian fields).
    localparam logic [4:0] HDR_ID_LEN   = 5'd0;
    localparam logic [4:0] HDR_IMG_TYPE = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_BPP      = 5'd16;
    localparam logic [4:0] HDR_LAST     = 5'd17;

    // Supported image types and pixel sizes.
    localparam logic [7:0] IMG_TRUECOLOR = 8'd2;
    localparam logic [7:0] IMG_RLE       = 8'd10;
    localparam logic [7:0] BPP_24        = 8'd24;
    localparam logic [7:0] BPP_32        = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

    // Pixel byte positions within one BGR(A) pixel.
    localparam logic [1:0] PB_BLUE  = 2'd0;
    localparam logic [1:0] PB_GREEN = 2'd1;
    localparam logic [1:0] PB_RED   = 2'd2;
    localparam logic [1:0] PB_ALPHA = 2'd3;

    // Position divider: three quotient bits per cycle, nine bits in all.
    localparam int         DIV_BITS_PER_STEP = 3;
    localparam logic [1:0] DIV_LAST_STEP     = 2'd2;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] start_row;
        logic [15:0] start_column;
        logic [7:0]  span_count;
        logic        image_done;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  pixel_bits;
    } t_result;

endpackage

FILE: hw/rtl/tga_rle_image_decoder.sv
// Truecolor TGA decoder: header parse, ID skip, raw and run-length pixel spans.
//
// Input channel (i_in_valid / o_in_ready) takes one file byte per transfer,
// with i_start_of_file marking header byte 0 of a new file. Output channel
// (o_out_valid / i_out_ready) delivers header results and RGBA pixel spans.
// Throughput is one byte per cycle while o_in_ready is high. A result is
// registered into the output register, or into the skid entry while the
// output is held. The output register is backed by a one-entry skid buffer,
// so bytes keep flowing while the receiver stalls; o_in_ready drops only
// when both output entries are full, and rises again the cycle after the
// receiver takes a result. After a run span the new row and column are
// computed by a small divider; the packet header and pixel bytes that must
// arrive before the next span let it finish, so it never stalls the input.
// Reset (synchronous, active low) clears the decoder state and empties the
// output (not the divider datapath or output payload); the first bytes after
// reset are taken as a header even without the start-of-file mark.
module tga_rle_image_decoder
    import tga_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [15:0] o_start_row,
    output logic [15:0] o_start_column,
    output logic [7:0]  o_span_count,
    output logic        o_image_done,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic [7:0]  o_pixel_bits
);

    // Decoder state.
    t_phase      r_phase, n_phase;
    logic [4:0]  r_hidx, n_hidx;
    logic [7:0]  r_id_left, n_id_left;
    logic [7:0]  r_img_kind, n_img_kind;
    logic [7:0]  r_bpp, n_bpp;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [15:0] r_cur_row, n_cur_row;
    logic [15:0] r_cur_col, n_cur_col;
    logic [7:0]  r_pkt_left, n_pkt_left;
    logic        r_pkt_run, n_pkt_run;
    logic [1:0]  r_byte_idx, n_byte_idx;
    logic [7:0]  r_blue, n_blue;
    logic [7:0]  r_green, n_green;
    logic [7:0]  r_red, n_red;
    logic [31:0] r_pix_left, n_pix_left;

    // Position divider.
    logic        r_div_busy, n_div_busy;
    logic [1:0]  r_div_step, n_div_step;
    logic [16:0] r_div_rem, n_div_rem;
    logic [24:0] r_div_dvs, n_div_dvs;
    logic [8:0]  r_div_quo, n_div_quo;
    logic [16:0] d_rem;
    logic [24:0] d_dvs;
    logic [8:0]  d_quo;

    // Output register and skid entry.
    logic        r_out_valid, r_skid_valid;
    t_result     r_out, r_skid;
    t_result     n_res;
    logic        n_res_valid;

    // Shared decode.
    logic        in_fire, out_fire, res_fire;
    t_phase      eff_phase;
    logic [4:0]  eff_hidx;
    t_phase      data_phase;
    logic        hdr_last, hdr_ok, hdr_empty;
    logic        pix_last, is_run_span, span_done;
    logic [7:0]  span_req, span_cnt;
    logic [31:0] img_pixels;
    logic [16:0] col_inc;

    assign o_in_ready = !r_skid_valid;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_out_valid && i_out_ready;
    assign res_fire   = in_fire && n_res_valid;

    // A start-of-file byte is always header byte 0.
    assign eff_phase  = i_start_of_file ? PH_HEADER : r_phase;
    assign eff_hidx   = i_start_of_file ? HDR_ID_LEN : r_hidx;
    assign data_phase = (r_img_kind == IMG_RLE) ? PH_PACKET : PH_PIXEL;

    // Header checks on the last header byte.
    assign hdr_last   = (eff_phase == PH_HEADER) && (eff_hidx == HDR_LAST);
    assign hdr_ok     = ((r_img_kind == IMG_TRUECOLOR) || (r_img_kind == IMG_RLE)) &&
                        ((r_bpp == BPP_24) || (r_bpp == BPP_32));
    assign hdr_empty  = (r_width == 16'd0) || (r_height == 16'd0);
    assign img_pixels = {16'd0, r_width} * {16'd0, r_height};

    // Span size, clipped to the pixels left in the image.
    assign pix_last    = (eff_phase == PH_PIXEL) &&
                         ((r_byte_idx == PB_ALPHA) ||
                          ((r_byte_idx == PB_RED) && (r_bpp == BPP_24)));
    assign is_run_span = (r_img_kind == IMG_RLE) && r_pkt_run;
    assign span_req    = is_run_span ? r_pkt_left : 8'd1;
    assign span_done   = ({24'd0, span_req} >= r_pix_left);
    assign span_cnt    = span_done ? r_pix_left[7:0] : span_req;
    assign col_inc     = {1'b0, r_cur_col} + 17'd1;

    // Restoring division steps: three compare-and-subtract stages per cycle.
    always_comb begin : div_step
        d_rem = r_div_rem;
        d_dvs = r_div_dvs;
        d_quo = r_div_quo;
        for (int j = 0; j < DIV_BITS_PER_STEP; j++) begin
            if ({8'd0, d_rem} >= d_dvs) begin
                d_rem = d_rem - d_dvs[16:0];
                d_quo = {d_quo[7:0], 1'b1};
            end else begin
                d_quo = {d_quo[7:0], 1'b0};
            end
            d_dvs = d_dvs >> 1;
        end
    end

    // Next state of the decoder and the divider.
    always_comb begin : next_state
        n_phase    = r_phase;
        n_hidx     = r_hidx;
        n_id_left  = r_id_left;
        n_img_kind = r_img_kind;
        n_bpp      = r_bpp;
        n_width    = r_width;
        n_height   = r_height;
        n_cur_row  = r_cur_row;
        n_cur_col  = r_cur_col;
        n_pkt_left = r_pkt_left;
        n_pkt_run  = r_pkt_run;
        n_byte_idx = r_byte_idx;
        n_blue     = r_blue;
        n_green    = r_green;
        n_red      = r_red;
        n_pix_left = r_pix_left;
        n_div_busy = r_div_busy;
        n_div_step = r_div_step;
        n_div_rem  = r_div_rem;
        n_div_dvs  = r_div_dvs;
        n_div_quo  = r_div_quo;

        // The divider finishes the position update of the last run span.
        if (r_div_busy) begin
            n_div_rem  = d_rem;
            n_div_dvs  = d_dvs;
            n_div_quo  = d_quo;
            n_div_step = r_div_step + 2'd1;
            if (r_div_step == DIV_LAST_STEP) begin
                n_div_busy = 1'b0;
                n_cur_col  = d_rem[15:0];
                n_cur_row  = r_cur_row - {7'd0, d_quo};
            end
        end

        if (in_fire) begin
            if (i_start_of_file) begin
                n_div_busy = 1'b0;
                n_phase    = PH_HEADER;
                n_hidx     = HDR_ID_LEN;
            end
            unique case (eff_phase)
                PH_HEADER: begin
                    unique case (eff_hidx)
                        HDR_ID_LEN:    n_id_left  = i_data_byte;
                        HDR_IMG_TYPE:  n_img_kind = i_data_byte;
                        HDR_WIDTH_LO:  n_width    = {8'd0, i_data_byte};
                        HDR_WIDTH_HI:  n_width    = {i_data_byte, r_width[7:0]};
                        HDR_HEIGHT_LO: n_height   = {8'd0, i_data_byte};
                        HDR_HEIGHT_HI: n_height   = {i_data_byte, r_height[7:0]};
                        HDR_BPP:       n_bpp      = i_data_byte;
                        default: ;
                    endcase
                    if (eff_hidx != HDR_LAST) begin
                        n_hidx = eff_hidx + 5'd1;
                    end else begin
                        n_hidx = HDR_ID_LEN;
                        if (!hdr_ok || hdr_empty) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_cur_row  = r_height - 16'd1;
                            n_cur_col  = 16'd0;
                            n_byte_idx = PB_BLUE;
                            n_pkt_left = 8'd0;
                            n_pkt_run  = 1'b0;
                            n_pix_left = img_pixels;
                            n_phase    = (r_id_left != 8'd0) ? PH_IDSKIP : data_phase;
                        end
                    end
                end
                PH_IDSKIP: begin
                    n_id_left = r_id_left - 8'd1;
                    if (r_id_left == 8'd1) begin
                        n_phase = data_phase;
                    end
                end
                PH_PACKET: begin
                    n_pkt_run  = i_data_byte[7];
                    n_pkt_left = {1'b0, i_data_byte[6:0]} + 8'd1;
                    n_byte_idx = PB_BLUE;
                    n_phase    = PH_PIXEL;
                end
                PH_PIXEL: begin
                    if (!pix_last) begin
                        n_byte_idx = r_byte_idx + 2'd1;
                        case (r_byte_idx)
                            PB_BLUE:  n_blue  = i_data_byte;
                            PB_GREEN: n_green = i_data_byte;
                            default:  n_red   = i_data_byte;
                        endcase
                    end else begin
                        n_byte_idx = PB_BLUE;
                        if (r_byte_idx == PB_RED) begin
                            n_red = i_data_byte;
                        end
                        if (span_done) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_pix_left = r_pix_left - {24'd0, span_cnt};
                            // Advance the position, wrapping down rows.
                            if (is_run_span) begin
                                n_div_busy = 1'b1;
                                n_div_step = 2'd0;
                                n_div_rem  = {1'b0, r_cur_col} + {9'd0, span_cnt};
                                n_div_dvs  = {1'b0, r_width, 8'd0};
                                n_div_quo  = 9'd0;
                            end else if (col_inc >= {1'b0, r_width}) begin
                                n_cur_col = 16'd0;
                                n_cur_row = r_cur_row - 16'd1;
                            end else begin
                                n_cur_col = col_inc[15:0];
                            end
                            // Packet bookkeeping for run-length data.
                            if (r_img_kind == IMG_RLE) begin
                                if (r_pkt_run) begin
                                    n_phase = PH_PACKET;
                                end else begin
                                    n_pkt_left = r_pkt_left - 8'd1;
                                    if (r_pkt_left == 8'd1) begin
                                        n_phase = PH_PACKET;
                                    end
                                end
                            end
                        end
                    end
                end
                PH_IDLE: ;
                default: ;
            endcase
        end
    end

    // Result for the byte at the input.
    always_comb begin : result_out
        n_res              = '0;
        n_res_valid        = 1'b0;
        n_res.image_width  = r_width;
        n_res.image_height = r_height;
        n_res.pixel_bits   = r_bpp;
        if (hdr_last) begin
            n_res_valid      = 1'b1;
            n_res.kind       = hdr_ok ? KIND_HDR_OK : KIND_HDR_BAD;
            n_res.image_done = !hdr_ok || hdr_empty;
        end else if (pix_last) begin
            n_res_valid        = 1'b1;
            n_res.kind         = KIND_SPAN;
            n_res.red          = (r_byte_idx == PB_RED) ? i_data_byte : r_red;
            n_res.green        = r_green;
            n_res.blue         = r_blue;
            n_res.alpha        = (r_byte_idx == PB_RED) ? ALPHA_OPAQUE : i_data_byte;
            n_res.start_row    = r_cur_row;
            n_res.start_column = r_cur_col;
            n_res.span_count   = span_cnt;
            n_res.image_done   = span_done;
        end
    end

    // Decoder state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hidx     <= HDR_ID_LEN;
            r_id_left  <= 8'd0;
            r_img_kind <= 8'd0;
            r_bpp      <= 8'd0;
            r_width    <= 16'd0;
            r_height   <= 16'd0;
            r_cur_row  <= 16'd0;
            r_cur_col  <= 16'd0;
            r_pkt_left <= 8'd0;
            r_pkt_run  <= 1'b0;
            r_byte_idx <= PB_BLUE;
            r_blue     <= 8'd0;
            r_green    <= 8'd0;
            r_red      <= 8'd0;
            r_pix_left <= 32'd0;
            r_div_busy <= 1'b0;
            r_div_step <= 2'd0;
        end else begin
            r_phase    <= n_phase;
            r_hidx     <= n_hidx;
            r_id_left  <= n_id_left;
            r_img_kind <= n_img_kind;
            r_bpp      <= n_bpp;
            r_width    <= n_width;
            r_height   <= n_height;
            r_cur_row  <= n_cur_row;
            r_cur_col  <= n_cur_col;
            r_pkt_left <= n_pkt_left;
            r_pkt_run  <= n_pkt_run;
            r_byte_idx <= n_byte_idx;
            r_blue     <= n_blue;
            r_green    <= n_green;
            r_red      <= n_red;
            r_pix_left <= n_pix_left;
            r_div_busy <= n_div_busy;
            r_div_step <= n_div_step;
        end
    end

    // Divider datapath registers.
    always_ff @(posedge i_clk) begin
        r_div_rem <= n_div_rem;
        r_div_dvs <= n_div_dvs;
        r_div_quo <= n_div_quo;
    end

    // Output and skid valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            r_out_valid  <= r_skid_valid || res_fire;
            r_skid_valid <= 1'b0;
        end else if (res_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output and skid payload.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (res_fire) begin
            r_skid <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_red          = r_out.red;
    assign o_green        = r_out.green;
    assign o_blue         = r_out.blue;
    assign o_alpha        = r_out.alpha;
    assign o_start_row    = r_out.start_row;
    assign o_start_column = r_out.start_column;
    assign o_span_count   = r_out.span_count;
    assign o_image_done   = r_out.image_done;
    assign o_image_width  = r_out.image_width;
    assign o_image_height = r_out.image_height;
    assign o_pixel_bits   = r_out.pixel_bits;

`ifndef ASSERT_OFF
    // The next span never arrives before the divider has updated the position.
    a_div_before_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> !(in_fire && pix_last))
        else $error("span completed while position divider busy");

    // The skid entry only fills behind a held output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // The span that completes the image stops decoding.
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_fire && (n_res.kind == KIND_SPAN) && n_res.image_done) |=>
        (r_phase == PH_IDLE))
        else $error("decoder not idle after final span");

    // Pixel data is only decoded while pixels remain in the image.
    a_pixels_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_PACKET) || (r_phase == PH_PIXEL)) |-> (r_pix_left != 32'd0))
        else $error("pixel phase with no pixels left");

    // The divider stops after its last step, unless a new file cancels it sooner.
    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_busy && (r_div_step == DIV_LAST_STEP)) |=> !r_div_busy)
        else $error("position divider overran");
`endif

endmodule
